>>> hw/rtl/iirdf1_pkg.sv
// Package: shared types and constants for the direct-form-I IIR filter.
`timescale 1ns / 1ps

package iirdf1_pkg;

    localparam int ACC_WIDTH  = 64;
    localparam int IDX_WIDTH  = 7;
    localparam int CMD_WIDTH  = 2;
    localparam int CFG_WIDTH  = 8;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [CFG_WIDTH-1:0] TAPS_RESET = 8'd100;

    localparam logic [CMD_WIDTH-1:0] CMD_FILTER  = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_LOAD_FF = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_LOAD_FB = 2'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_RESTART = 2'd3;

    typedef enum logic [2:0] {
        OP_FILTER,
        OP_LOAD_FF,
        OP_LOAD_FB,
        OP_RESTART,
        OP_SKIP
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FF,
        ST_FB,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_ctrl_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

endpackage

>>> hw/rtl/iirdf1_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iirdf1_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/iirdf1_front.sv
// Front end: accepts input beats, classifies commands and queues them for the back end.
`timescale 1ns / 1ps

module iirdf1_front
    import iirdf1_pkg::*;
#(
    parameter int MAX_TAPS     = 128,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CMD_WIDTH-1:0]           command,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [IDX_WIDTH-1:0]           coef_index,
    input  logic signed [COEF_WIDTH-1:0]   coef_value,
    input  back_stat_t                     stat,
    output q_ctrl_t                        q_ctrl,
    output logic [SAMPLE_WIDTH-1:0]        q_sample,
    output logic [$clog2(MAX_TAPS)-1:0]    q_idx,
    output logic [COEF_WIDTH-1:0]          q_coef
);

    localparam int AW = $clog2(MAX_TAPS);

    op_t                    op_reg     [Q_DEPTH];
    logic [SAMPLE_WIDTH-1:0] sample_reg [Q_DEPTH];
    logic [AW-1:0]          idx_reg    [Q_DEPTH];
    logic [COEF_WIDTH-1:0]  coef_reg   [Q_DEPTH];

    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    logic        push;
    logic        idx_ok;
    logic [31:0] idx_wide;
    op_t         op_class;

    assign idx_wide = 32'(coef_index);
    assign idx_ok   = idx_wide < 32'(MAX_TAPS);

    always_comb
    begin
        case (command)
            CMD_FILTER:  op_class = OP_FILTER;
            CMD_LOAD_FF: op_class = idx_ok ? OP_LOAD_FF : OP_SKIP;
            CMD_LOAD_FB: op_class = idx_ok ? OP_LOAD_FB : OP_SKIP;
            CMD_RESTART: op_class = OP_RESTART;
            default:     op_class = OP_SKIP;
        endcase
    end

    assign in_ready = (count_reg != Q_CNT_W'(Q_DEPTH)) && !stat.clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (stat.pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !stat.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && stat.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]     <= op_class;
            sample_reg[wr_ptr_reg] <= sample_in;
            idx_reg[wr_ptr_reg]    <= idx_wide[AW-1:0];
            coef_reg[wr_ptr_reg]   <= coef_value;
        end
    end

    assign q_ctrl.valid = count_reg != '0;
    assign q_ctrl.op    = op_reg[rd_ptr_reg];
    assign q_sample     = sample_reg[rd_ptr_reg];
    assign q_idx        = idx_reg[rd_ptr_reg];
    assign q_coef       = coef_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/iirdf1_back.sv
// Back end: coefficient and history memories, shared MAC sequencer and output register.
`timescale 1ns / 1ps

module iirdf1_back
    import iirdf1_pkg::*;
#(
    parameter int MAX_TAPS     = 128,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  q_ctrl_t                          q_ctrl,
    input  logic [SAMPLE_WIDTH-1:0]          q_sample,
    input  logic [$clog2(MAX_TAPS)-1:0]      q_idx,
    input  logic [COEF_WIDTH-1:0]            q_coef,
    output back_stat_t                       stat,
    input  logic [$clog2(MAX_TAPS+1)-1:0]    taps,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
    output logic                             saturated
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int RAW    = AW + 1;
    localparam int RDEPTH = 2 ** RAW;
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int CF     = COEF_WIDTH - 4;
    localparam int PW     = SAMPLE_WIDTH + COEF_WIDTH;

    localparam logic [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (CF - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        (ACC_WIDTH'(1) << (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0)
        begin
            r = AW'(MAX_TAPS - 1);
        end
        else
        begin
            r = p - 1'b1;
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [RAW-1:0] clr_reg, clr_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [TW-1:0]  fill_reg, fill_next;
    logic [TW-1:0]  k_reg, k_next;
    logic [AW-1:0]  ptr_reg, ptr_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_live_reg, s1_live_next;
    logic s1_neg_reg, s1_neg_next;
    logic s2_valid_reg, s2_valid_next;
    logic s2_neg_reg, s2_neg_next;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic [ACC_WIDTH-1:0]        acc_reg, acc_next;
    logic signed [ACC_WIDTH-1:0] rnd_reg, rnd_next;

    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] sample_out_reg, sample_out_next;
    logic                    saturated_reg, saturated_next;

    logic                    coef_we, hist_we;
    logic [RAW-1:0]          coef_waddr, hist_waddr, coef_raddr, hist_raddr;
    logic [COEF_WIDTH-1:0]   coef_wdata, coef_rdata;
    logic [SAMPLE_WIDTH-1:0] hist_wdata, hist_rdata;

    logic                        fb_sel, issue, issue_neg, issue_live, last_tap;
    logic [TW-1:0]               taps_m1;
    logic signed [PW-1:0]        prod_mult;
    logic signed [ACC_WIDTH-1:0] prod_ext;
    logic signed [ACC_WIDTH-1:0] shifted;
    logic                        sat_hi, sat_lo;
    logic [SAMPLE_WIDTH-1:0]     y_val;

    iirdf1_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (RDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    iirdf1_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (RDEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Upper address bit selects the feedback half of each memory.
    assign fb_sel     = state_reg == ST_FB;
    assign coef_raddr = {fb_sel, k_reg[AW-1:0]};
    assign hist_raddr = {fb_sel, ptr_reg};
    assign taps_m1    = taps - TW'(1);
    assign last_tap   = k_reg == taps_m1;
    assign issue_live = k_reg <= fill_reg;

    assign prod_mult = $signed(coef_rdata) * $signed(hist_rdata);
    assign prod_ext  = ACC_WIDTH'(prod_reg);

    assign shifted = rnd_reg >>> CF;
    assign sat_hi  = shifted > SAT_HI;
    assign sat_lo  = shifted < SAT_LO;

    always_comb
    begin
        if (sat_hi)
        begin
            y_val = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (sat_lo)
        begin
            y_val = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_val = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        ptr_next        = ptr_reg;
        rnd_next        = rnd_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        saturated_next  = saturated_reg;
        coef_we         = 1'b0;
        coef_waddr      = '0;
        coef_wdata      = '0;
        hist_we         = 1'b0;
        hist_waddr      = '0;
        hist_wdata      = '0;
        issue           = 1'b0;
        issue_neg       = 1'b0;
        stat.pop        = 1'b0;
        stat.clearing   = state_reg == ST_CLEAR;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                coef_we    = 1'b1;
                coef_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_ctrl.valid)
                begin
                    stat.pop = 1'b1;
                    case (q_ctrl.op)
                        OP_FILTER:
                        begin
                            hist_we    = 1'b1;
                            hist_waddr = {1'b0, head_reg};
                            hist_wdata = q_sample;
                            k_next     = '0;
                            ptr_next   = head_reg;
                            state_next = ST_FF;
                        end
                        OP_LOAD_FF:
                        begin
                            coef_we    = 1'b1;
                            coef_waddr = {1'b0, q_idx};
                            coef_wdata = q_coef;
                        end
                        OP_LOAD_FB:
                        begin
                            coef_we    = 1'b1;
                            coef_waddr = {1'b1, q_idx};
                            coef_wdata = q_coef;
                        end
                        OP_RESTART:
                        begin
                            head_next = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FF:
            begin
                issue = 1'b1;
                if (last_tap)
                begin
                    if (taps_m1 == '0)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next     = TW'(1);
                        ptr_next   = ptr_dec(head_reg);
                        state_next = ST_FB;
                    end
                end
                else
                begin
                    k_next   = k_reg + TW'(1);
                    ptr_next = ptr_dec(ptr_reg);
                end
            end
            ST_FB:
            begin
                issue     = 1'b1;
                issue_neg = 1'b1;
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next   = k_reg + TW'(1);
                    ptr_next = ptr_dec(ptr_reg);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                rnd_next   = $signed(acc_reg + ROUND_HALF);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = y_val;
                    saturated_next  = sat_hi || sat_lo;
                    hist_we         = 1'b1;
                    hist_waddr      = {1'b1, head_reg};
                    hist_wdata      = y_val;
                    if (head_reg == AW'(MAX_TAPS - 1))
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    if (fill_reg != TW'(MAX_TAPS))
                    begin
                        fill_next = fill_reg + TW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // MAC pipeline: RAM read, multiply, accumulate.
    always_comb
    begin
        s1_valid_next = issue;
        s1_live_next  = issue_live;
        s1_neg_next   = issue_neg;
        s2_valid_next = s1_valid_reg;
        s2_neg_next   = s1_neg_reg;
        prod_next     = s1_live_reg ? prod_mult : '0;
        acc_next      = acc_reg;
        if (state_reg == ST_IDLE)
        begin
            acc_next = '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_neg_reg)
            begin
                acc_next = acc_reg - prod_ext;
            end
            else
            begin
                acc_next = acc_reg + prod_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        ptr_reg        <= ptr_next;
        s1_live_reg    <= s1_live_next;
        s1_neg_reg     <= s1_neg_next;
        s2_neg_reg     <= s2_neg_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        rnd_reg        <= rnd_next;
        sample_out_reg <= sample_out_next;
        saturated_reg  <= saturated_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule

>>> hw/rtl/iir_direct_form_one_filter_top.sv
// Top level: direct-form-I IIR filter with command queue and shared MAC back end.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat: filter a
//   sample, load a feedforward or feedback coefficient, or restart the stream.
//   Only a filter beat yields an output beat (out_valid/out_ready) with the
//   rounded, saturated sample and its clip flag.
//   A two-entry queue sits between the front end and the back end, so input
//   beats are taken while a finished sample waits at the output register.
//   With T taps in use, a sample occupies the single multiply-accumulate unit
//   for T feedforward and T-1 feedback reads (one coefficient/history read per
//   cycle); the pipeline then drains and the sum is rounded. Loads and restarts
//   are done in the idle state. After reset all 2*2^ceil(log2 MAX_TAPS)
//   coefficient memory entries (256 at the default depth) are swept to zero;
//   in_ready stays low meanwhile. If the receiver stalls, the result holds in
//   the output register and the back end waits there; the queue fills and
//   in_ready drops. The user must write taps_reg through
//   cfg_write_enable/cfg_write_data only while idle; the block never checks.
`timescale 1ns / 1ps

module iir_direct_form_one_filter_top
    import iirdf1_pkg::*;
#(
    parameter int MAX_TAPS     = 128,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_enable,
    input  logic [CFG_WIDTH-1:0]           cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CMD_WIDTH-1:0]           command,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [IDX_WIDTH-1:0]           coef_index,
    input  logic signed [COEF_WIDTH-1:0]   coef_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           saturated
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);

    logic [CFG_WIDTH-1:0] taps_reg, taps_next;
    logic [31:0]          taps_wide;
    logic [TW-1:0]        taps_eff;

    q_ctrl_t                 q_ctrl;
    back_stat_t              stat;
    logic [SAMPLE_WIDTH-1:0] q_sample;
    logic [AW-1:0]           q_idx;
    logic [COEF_WIDTH-1:0]   q_coef;

    assign taps_next = cfg_write_enable ? cfg_write_data : taps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_RESET;
        end
        else
        begin
            taps_reg <= taps_next;
        end
    end

    always_comb
    begin
        if (taps_reg == '0)
        begin
            taps_wide = 32'd1;
        end
        else if (32'(taps_reg) > 32'(MAX_TAPS))
        begin
            taps_wide = 32'(MAX_TAPS);
        end
        else
        begin
            taps_wide = 32'(taps_reg);
        end
    end

    assign taps_eff = taps_wide[TW-1:0];

    iirdf1_front #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .stat       (stat),
        .q_ctrl     (q_ctrl),
        .q_sample   (q_sample),
        .q_idx      (q_idx),
        .q_coef     (q_coef)
    );

    iirdf1_back #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctrl     (q_ctrl),
        .q_sample   (q_sample),
        .q_idx      (q_idx),
        .q_coef     (q_coef),
        .stat       (stat),
        .taps       (taps_eff),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

endmodule

>>> hw/rtl/iirdf1_checker.sv
// Checker: port-level assertions for the IIR filter top level, with its bind.
`timescale 1ns / 1ps

module iirdf1_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] sample_out,
    input logic                    saturated
);

    localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out) && $stable(saturated))
        else $error("output payload changed while stalled");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> sample_out == OUT_MAX || sample_out == OUT_MIN)
        else $error("clip flag set on a sample that is not at a rail");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input taken during coefficient sweep after reset");

endmodule

bind iir_direct_form_one_filter_top iirdf1_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf1_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .saturated  (saturated)
);

>>> bench/iir_direct_form_one_filter_top_test.sv
// Self-checking testbench for the direct-form-I IIR filter: directed table, random phases.
`timescale 1ns / 1ps

module iir_direct_form_one_filter_top_test;
    import iirdf1_pkg::*;

    localparam int MAX_TAPS     = 128;
    localparam int ITEM_TARGET  = 800;
    localparam int DRAIN_CYCLES = 2 * MAX_TAPS + 16;
    localparam int HOLD_CYCLES  = 1200;

    typedef struct packed {
        int                   taps;   // register value to write first; -1 leaves it
        logic [CMD_WIDTH-1:0] cmd;
        logic signed [15:0]   x;
        logic [IDX_WIDTH-1:0] idx;
        logic signed [15:0]   c;
        bit                   known;
        logic signed [15:0]   y;
        logic                 sat;
    } step_t;

    typedef struct packed {
        logic signed [15:0] y;
        logic               sat;
    } out_beat_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_enable;
    logic [CFG_WIDTH-1:0]    cfg_write_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_WIDTH-1:0]    command;
    logic signed [15:0]      sample_in;
    logic [IDX_WIDTH-1:0]    coef_index;
    logic signed [15:0]      coef_value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [15:0]      sample_out;
    logic                    saturated;

    logic signed [15:0]   x_hist [MAX_TAPS];
    logic signed [15:0]   y_hist [MAX_TAPS];
    logic signed [15:0]   ff_coef [MAX_TAPS];
    logic signed [15:0]   fb_coef [MAX_TAPS];
    logic [IDX_WIDTH-1:0] hist_head;
    logic [CFG_WIDTH-1:0] taps_reg;

    out_beat_t expected_outputs[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        beats_sent   = 0;
    bit        press_req    = 1'b0;

    iir_direct_form_one_filter_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .sample_in        (sample_in),
        .coef_index       (coef_index),
        .coef_value       (coef_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sample_out       (sample_out),
        .saturated        (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_histories();
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            x_hist[i] = '0;
            y_hist[i] = '0;
        end
        hist_head = '0;
    endfunction

    // Applies one command to the model state; returns 1 with the output for a filter beat.
    function automatic bit iir_step(input step_t s, output out_beat_t o);
        longint acc;
        longint r;
        int     taps;
        int     pos;
        o = '0;
        case (s.cmd)
            CMD_LOAD_FF:
            begin
                ff_coef[s.idx] = s.c;
                return 1'b0;
            end
            CMD_LOAD_FB:
            begin
                fb_coef[s.idx] = s.c;
                return 1'b0;
            end
            CMD_RESTART:
            begin
                clear_histories();
                return 1'b0;
            end
            default:
            begin
                taps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg));
                x_hist[hist_head] = s.x;
                acc = 0;
                for (int k = 0; k < taps; k++)
                begin
                    pos = (int'(hist_head) + MAX_TAPS - k) % MAX_TAPS;
                    acc += longint'(ff_coef[k]) * longint'(x_hist[pos]);
                end
                for (int k = 1; k < taps; k++)
                begin
                    pos = (int'(hist_head) + MAX_TAPS - k) % MAX_TAPS;
                    acc -= longint'(fb_coef[k]) * longint'(y_hist[pos]);
                end
                r = (acc + 64'sd2048) >>> 12;
                if (r > 32767)
                begin
                    o.y = 16'h7FFF;
                    o.sat = 1'b1;
                end
                else if (r < -32768)
                begin
                    o.y = 16'h8000;
                    o.sat = 1'b1;
                end
                else
                begin
                    o.y = 16'(r);
                    o.sat = 1'b0;
                end
                y_hist[hist_head] = o.y;
                hist_head = hist_head + 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic step_t beat(input logic [CMD_WIDTH-1:0] cmd, input logic signed [15:0] x,
                                   input logic [IDX_WIDTH-1:0] idx, input logic signed [15:0] c);
        step_t s;
        s = '0;
        s.taps = -1;
        s.cmd  = cmd;
        s.x    = x;
        s.idx  = idx;
        s.c    = c;
        return s;
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_taps(input int v);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= CFG_WIDTH'(v);
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        taps_reg = CFG_WIDTH'(v);
    endtask

    task automatic send_beat(input step_t s);
        out_beat_t o;
        bit        calm;
        if (s.taps >= 0)
        begin
            settle();
            write_taps(s.taps);
        end
        calm = (beats_sent >= 300 && beats_sent < 420);
        if (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= s.cmd;
        sample_in  <= s.x;
        coef_index <= s.idx;
        coef_value <= s.c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (iir_step(s, o))
        begin
            if (s.known)
            begin
                o.y   = s.y;
                o.sat = s.sat;
            end
            expected_outputs.insert(expected_outputs.size(), o);
        end
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held && press_req)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (results_seen >= 200 && results_seen < 300)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_outputs.size() == 0)
            begin
                $error("output beat with nothing expected: sample_out %0d saturated %0d",
                       sample_out, saturated);
                mismatches++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (sample_out !== want.y)
                begin
                    $error("sample_out: expected %0d, actual %0d", want.y, sample_out);
                    mismatches++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %0d, actual %0d", want.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        step_t              plan [25];
        int                 pick;
        int                 t;
        int                 eff;
        int                 n;
        int                 idx;
        bit                 ff;
        bit                 press;
        logic signed [15:0] c;
        logic signed [15:0] x;

        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_write_data   <= '0;
        in_valid         <= 1'b0;
        command          <= CMD_FILTER;
        sample_in        <= '0;
        coef_index       <= '0;
        coef_value       <= '0;

        clear_histories();
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            ff_coef[i] = '0;
            fb_coef[i] = '0;
        end
        taps_reg = TAPS_RESET;

        plan = '{
            '{-1,  CMD_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h0000, 1'b0},
            '{-1,  CMD_FILTER,  16'h8000, 7'd127, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
            '{-1,  CMD_LOAD_FF, 16'h0000, 7'd0,   16'h1000, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h7FFF, 1'b0},
            '{-1,  CMD_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b1, 16'h8000, 1'b0},
            '{-1,  CMD_LOAD_FF, 16'hFFFF, 7'd0,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h7FFF, 1'b1},
            '{-1,  CMD_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b1, 16'h8000, 1'b1},
            '{-1,  CMD_LOAD_FF, 16'h0000, 7'd0,   16'h8000, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b1, 16'h7FFF, 1'b1},
            '{-1,  CMD_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h8000, 1'b1},
            '{-1,  CMD_RESTART, 16'hFFFF, 7'd127, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_LOAD_FF, 16'h0000, 7'd0,   16'h0800, 1'b0, 16'h0000, 1'b0},
            // half an LSB rounds up for both signs
            '{-1,  CMD_FILTER,  16'h0001, 7'd0,   16'h0000, 1'b1, 16'h0001, 1'b0},
            '{-1,  CMD_FILTER,  16'hFFFF, 7'd0,   16'h0000, 1'b1, 16'h0000, 1'b0},
            // feedback tap 0 never enters the sum
            '{-1,  CMD_LOAD_FB, 16'h0000, 7'd0,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_LOAD_FF, 16'h0000, 7'd127, 16'h1000, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_LOAD_FB, 16'h0000, 7'd127, 16'h8000, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_LOAD_FB, 16'h0000, 7'd1,   16'hF800, 1'b0, 16'h0000, 1'b0},
            // tap count of zero acts as one, above the maximum acts as the maximum
            '{0,   CMD_FILTER,  16'h3039, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
            '{255, CMD_FILTER,  16'hB1E0, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
            '{129, CMD_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
            '{1,   CMD_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
            '{128, CMD_FILTER,  16'h0064, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
            '{-1,  CMD_FILTER,  16'hFF9C, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        foreach (plan[i])
            send_beat(plan[i]);

        while (beats_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                t = $urandom_range(1, 12);
            else if (pick == 6)
                t = $urandom_range(13, 64);
            else if (pick == 7)
                t = 100;
            else if (pick == 8)
                t = $urandom_range(128, 255);
            else
                t = 0;
            settle();
            write_taps(t);
            eff = (t == 0) ? 1 : ((t > MAX_TAPS) ? MAX_TAPS : t);

            if ($urandom_range(0, 3) != 0)
                send_beat(beat(CMD_RESTART, 16'($urandom()), 7'($urandom()), 16'($urandom())));

            n = $urandom_range(1, 8);
            repeat (n)
            begin
                ff  = $urandom_range(0, 1);
                idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, eff - 1);
                if ($urandom_range(0, 7) == 0)
                    c = 16'($urandom());
                else if (ff)
                    c = 16'(int'($urandom_range(0, 4095)) - 2048);
                else
                    c = 16'(int'($urandom_range(0, 1023)) - 512);
                send_beat(beat(ff ? CMD_LOAD_FF : CMD_LOAD_FB, 16'($urandom()), 7'(idx), c));
            end

            // one long run of samples while the receiver holds off
            press = !press_req && beats_sent >= 200;
            n = press ? 32 : $urandom_range(8, 32);
            press_req = press_req || press;
            repeat (n)
            begin
                if (!press && $urandom_range(0, 9) == 0)
                    send_beat(beat(2'($urandom()), 16'($urandom()), 7'($urandom()),
                                   16'($urandom())));
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        x = 16'(int'($urandom_range(0, 511)) - 256);
                    else
                        x = 16'($urandom());
                    send_beat(beat(CMD_FILTER, x, 7'($urandom()), 16'($urandom())));
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
